// ----- hw/rtl/tcc_pkg.sv -----
// Shared types and constants for the text console with cursor and scroll.
// No dependencies; every other file uses this package.
package tcc_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic               scrolled;
  } res_t;

endpackage

// ----- hw/rtl/tcc_if.sv -----
// Handshake channels of the console: command, result and colour write.
// Depends on tcc_pkg for the field widths.
interface tcc_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [tcc_pkg::CHAR_W-1:0] char_code;
  logic [tcc_pkg::ROW_W-1:0]  read_row;
  logic [tcc_pkg::COL_W-1:0]  read_col;
  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::CHAR_W-1:0]  cell_char;
  logic [tcc_pkg::COLOR_W-1:0] cell_color;
  logic [tcc_pkg::ROW_W-1:0]   cursor_row;
  logic [tcc_pkg::COL_W-1:0]   cursor_col;
  logic                        scrolled;
  modport source (output valid, cell_char, cell_color, cursor_row, cursor_col, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, cell_color, cursor_row, cursor_col, scrolled,
                  output ready);
endinterface

interface tcc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::COLOR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/tcc_core.sv -----
// Cell store, cursor and row-offset ring with the command sequencer.
// Depends on tcc_pkg and the channel interfaces in tcc_if.sv.
module tcc_core #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  tcc_cmd_if.sink        cmd,
  tcc_cfg_if.sink        cfg,
  output logic           res_valid,
  input  logic           res_ready,
  output tcc_pkg::res_t  res
);
  import tcc_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int DEPTH = ROWS << CW;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_BLANK, S_DONE} state_t;

  state_t              state;
  logic [RW-1:0]       cur_y;
  logic [CW-1:0]       cur_x;
  logic [RW-1:0]       top;     // physical row shown as logical row 0
  logic [COLOR_W-1:0]  color;
  logic [RW-1:0]       blk_row;
  logic [CW-1:0]       blk_col;

  // cell store, physical address {row, column}
  logic [CELL_W-1:0]   mem [DEPTH];
  logic [CELL_W-1:0]   rd_data;
  logic                mem_we;
  logic [RW+CW-1:0]    mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [RW+CW-1:0]    mem_raddr;

  logic                accept;
  logic                rd_in_range;
  logic [RW-1:0]       rd_row;
  logic [RW:0]         sum_cur;
  logic [RW:0]         sum_rd;
  logic [RW-1:0]       phys_cur;
  logic [RW-1:0]       phys_rd;
  logic [RW-1:0]       top_inc;
  logic                wrap;
  logic                do_scroll;
  logic [RW-1:0]       nx_y;
  logic [CW-1:0]       nx_x;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = cmd.valid && cmd.ready;
  assign res_valid = (state == S_DONE);

  // logical to physical row through the ring offset
  always_comb begin
    sum_cur = {1'b0, cur_y} + {1'b0, top};
    if (sum_cur >= (RW+1)'(ROWS)) sum_cur = sum_cur - (RW+1)'(ROWS);
    phys_cur = sum_cur[RW-1:0];
    rd_row   = RW'(cmd.read_row);
    sum_rd   = {1'b0, rd_row} + {1'b0, top};
    if (sum_rd >= (RW+1)'(ROWS)) sum_rd = sum_rd - (RW+1)'(ROWS);
    phys_rd  = sum_rd[RW-1:0];
    top_inc  = (top == LAST_ROW) ? '0 : top + 1'b1;
  end

  assign rd_in_range = (32'(cmd.read_row) < ROWS) && (32'(cmd.read_col) < COLUMNS);

  always_comb begin
    wrap      = (cmd.char_code == NEWLINE_CODE) || (cur_x == LAST_COL);
    do_scroll = wrap && (cur_y == LAST_ROW);
    nx_x      = wrap ? '0 : cur_x + 1'b1;
    nx_y      = (wrap && !do_scroll) ? cur_y + 1'b1 : cur_y;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {blk_row, blk_col};
    mem_wdata = {color, BLANK_CODE};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_COLOR, BLANK_CODE};
      end
      S_BLANK: mem_we = 1'b1;
      S_IDLE: begin
        if (accept && cmd.command == CMD_PUT && cmd.char_code != NEWLINE_CODE) begin
          mem_we    = 1'b1;
          mem_waddr = {phys_cur, cur_x};
          mem_wdata = {color, cmd.char_code};
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign mem_re    = accept && (cmd.command == CMD_READ) && rd_in_range;
  assign mem_raddr = {phys_rd, CW'(cmd.read_col)};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cur_y   <= '0;
      cur_x   <= '0;
      top     <= '0;
      color   <= RESET_COLOR;
      blk_row <= '0;
      blk_col <= '0;
    end else begin
      if (cfg.valid) color <= cfg.data;
      case (state)
        S_CLEAR: begin
          if (blk_col == LAST_COL) begin
            blk_col <= '0;
            if (blk_row == LAST_ROW) begin
              blk_row <= '0;
              state   <= S_IDLE;
            end else begin
              blk_row <= blk_row + 1'b1;
            end
          end else begin
            blk_col <= blk_col + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res.cell_char  <= '0;
            res.cell_color <= '0;
            if (cmd.command == CMD_READ) begin
              res.cursor_row <= ROW_W'(cur_y);
              res.cursor_col <= COL_W'(cur_x);
              res.scrolled   <= 1'b0;
              state          <= rd_in_range ? S_READ : S_DONE;
            end else begin
              cur_x          <= nx_x;
              cur_y          <= nx_y;
              res.cursor_row <= ROW_W'(nx_y);
              res.cursor_col <= COL_W'(nx_x);
              res.scrolled   <= do_scroll;
              if (do_scroll) begin
                // old top row becomes the new bottom row
                blk_row <= top;
                blk_col <= '0;
                top     <= top_inc;
                state   <= S_BLANK;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_READ: begin
          res.cell_char  <= rd_data[CHAR_W-1:0];
          res.cell_color <= rd_data[CELL_W-1:CHAR_W];
          state          <= S_DONE;
        end
        S_BLANK: begin
          if (blk_col == LAST_COL) state <= S_DONE;
          else blk_col <= blk_col + 1'b1;
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_x} < (CW+1)'(COLUMNS)) && ({1'b0, cur_y} < (RW+1)'(ROWS)))
    else $error("cursor outside the screen");

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, top} < (RW+1)'(ROWS))
    else $error("ring offset outside the screen");

  a_blank_full_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLANK && blk_col != LAST_COL) |=> (state == S_BLANK))
    else $error("row blank ended early");

  a_read_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ($past(state) == S_IDLE && $past(mem_re)))
    else $error("read wait without a memory read");

endmodule

// ----- hw/rtl/tcc_out_reg.sv -----
// Output register between the sequencer and the result channel.
// Depends on tcc_pkg and tcc_rsp_if.
module tcc_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcc_pkg::res_t  in_data,
  tcc_rsp_if.source      rsp
);
  import tcc_pkg::*;

  logic full;
  res_t data;

  assign in_ready = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      if (in_valid && in_ready) full <= 1'b1;
      else if (rsp.ready) full <= 1'b0;
    end
    if (in_valid && in_ready) data <= in_data;
  end

  assign rsp.valid      = full;
  assign rsp.cell_char  = data.cell_char;
  assign rsp.cell_color = data.cell_color;
  assign rsp.cursor_row = data.cursor_row;
  assign rsp.cursor_col = data.cursor_col;
  assign rsp.scrolled   = data.scrolled;

endmodule

// ----- hw/rtl/text_console_cursor_scroll.sv -----
// Text console: command channel (put byte or read cell), result channel with
// one beat per command, and a colour write channel that is always ready.
// Put: a newline moves the cursor to column 0 of the next row; any other byte
// is stored at the cursor in the current colour and the cursor advances.
// Leaving the last row scrolls: the row-offset ring advances one row and the
// new bottom row is blanked in the current colour, one cell a cycle.
// A put goes from the command beat to S_DONE; a put with scroll first passes
// S_BLANK, which blanks the row through the single write port of the cell
// store; a read in range passes S_READ, one out of range goes straight to
// S_DONE. One command is in work at a time; the next is taken once the
// previous result sits in the output register. After reset a clearing pass
// writes space in colour 0x07 to every cell, during which no command is
// taken; colour writes are taken throughout.
// If the receiver stalls, the result waits in the output register, one more
// command may finish behind it, then the command channel holds off.
// Depends on tcc_pkg, tcc_if.sv, tcc_core and tcc_out_reg.
module text_console_cursor_scroll #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tcc_cmd_if.sink   cmd,
  tcc_cfg_if.sink   cfg,
  tcc_rsp_if.source rsp
);
  import tcc_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;

  tcc_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tcc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_data  (res),
    .rsp      (rsp)
  );

endmodule
